@@ src/bbn_pkg.sv @@
// Shared constants, widths and types for the bounding-box normalisation block.
// No dependencies.
package bbn_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int CW       = COORD_BITS;
  localparam int SUM_W    = CW + 1;
  localparam int DIFF_W   = CW + 2;
  localparam int EXT_W    = CW;
  localparam int SCALE_W  = 32;
  localparam int OUT_W    = 34;
  localparam int PROD_W   = SCALE_W + 1 + DIFF_W;
  localparam int SH_XZ    = 32 - FRAC_BITS;
  localparam int SH_Y     = 31 - FRAC_BITS;
  localparam int CNT_W    = $clog2(SCALE_W);
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);

  localparam logic [SCALE_W-1:0] ONE_Q31 = {1'b1, {(SCALE_W-1){1'b0}}};

  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_APPLY   = 1'b1;
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  // rec = 1: box of a finished mesh; rec = 0: vertex carried in the min fields
  typedef struct packed {
    logic                 rec;
    logic signed [CW-1:0] min_x;
    logic signed [CW-1:0] max_x;
    logic signed [CW-1:0] min_y;
    logic signed [CW-1:0] max_y;
    logic signed [CW-1:0] min_z;
    logic signed [CW-1:0] max_z;
  } bbn_entry_t;

  typedef struct packed {
    logic       push;
    bbn_entry_t entry;
  } bbn_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bbn_qstat_t;

endpackage

@@ src/bbn_if.sv @@
// Request channels of the block: vertex input and result output.
// Depends on bbn_pkg.
interface bbn_vtx_if import bbn_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic signed [CW-1:0] vx;
  logic signed [CW-1:0] vy;
  logic signed [CW-1:0] vz;
  logic                 last;

  modport source (output valid, cmd, vx, vy, vz, last, input ready);
  modport sink   (input valid, cmd, vx, vy, vz, last, output ready);
endinterface

interface bbn_res_if import bbn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [OUT_W-1:0] out_x;
  logic signed [OUT_W-1:0] out_y;
  logic signed [OUT_W-1:0] out_z;
  logic [SCALE_W-1:0]      norm_scale_out;
  logic                    degenerate;

  modport source (output valid, kind, out_x, out_y, out_z, norm_scale_out, degenerate,
                  input ready);
  modport sink   (input valid, kind, out_x, out_y, out_z, norm_scale_out, degenerate,
                  output ready);
endinterface

@@ src/bbn_front.sv @@
// Front end: accepts vertex requests, grows the box, queues apply and record jobs.
// Depends on bbn_pkg and bbn_vtx_if.
module bbn_front import bbn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  bbn_vtx_if.sink     vtx,
  input  bbn_qstat_t  qstat,
  output bbn_push_t   qpush
);

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  logic signed [CW-1:0] box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z;
  logic signed [CW-1:0] nmin_x, nmax_x, nmin_y, nmax_y, nmin_z, nmax_z;
  logic                 accept;

  assign vtx.ready = !qstat.full;
  assign accept    = vtx.valid && vtx.ready;

  always_comb begin
    nmin_x = (vtx.vx < box_min_x) ? vtx.vx : box_min_x;
    nmax_x = (vtx.vx > box_max_x) ? vtx.vx : box_max_x;
    nmin_y = (vtx.vy < box_min_y) ? vtx.vy : box_min_y;
    nmax_y = (vtx.vy > box_max_y) ? vtx.vy : box_max_y;
    nmin_z = (vtx.vz < box_min_z) ? vtx.vz : box_min_z;
    nmax_z = (vtx.vz > box_max_z) ? vtx.vz : box_max_z;

    qpush.push = accept && ((vtx.cmd == CMD_APPLY) || vtx.last);
    qpush.entry.rec = (vtx.cmd == CMD_MEASURE);
    if (vtx.cmd == CMD_APPLY) begin
      qpush.entry.min_x = vtx.vx;
      qpush.entry.min_y = vtx.vy;
      qpush.entry.min_z = vtx.vz;
    end else begin
      qpush.entry.min_x = nmin_x;
      qpush.entry.min_y = nmin_y;
      qpush.entry.min_z = nmin_z;
    end
    qpush.entry.max_x = nmax_x;
    qpush.entry.max_y = nmax_y;
    qpush.entry.max_z = nmax_z;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && vtx.cmd == CMD_MEASURE && vtx.last)) begin
      box_min_x <= COORD_MAX;
      box_max_x <= COORD_MIN;
      box_min_y <= COORD_MAX;
      box_max_y <= COORD_MIN;
      box_min_z <= COORD_MAX;
      box_max_z <= COORD_MIN;
    end else if (accept && vtx.cmd == CMD_MEASURE) begin
      box_min_x <= nmin_x;
      box_max_x <= nmax_x;
      box_min_y <= nmin_y;
      box_max_y <= nmax_y;
      box_min_z <= nmin_z;
      box_max_z <= nmax_z;
    end
  end

endmodule

@@ src/bbn_queue.sv @@
// Short job queue between the front end and the back end.
// Depends on bbn_pkg.
module bbn_queue import bbn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  bbn_push_t  qpush,
  input  logic       pop,
  output bbn_entry_t head,
  output bbn_qstat_t qstat
);

  bbn_entry_t         mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic               do_push, do_pop;

  assign qstat.full  = (count == (Q_PTR_W + 1)'(Q_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = qpush.push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= qpush.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_PTR_W + 1)'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !qpush.push)
    else $error("push into full queue");

endmodule

@@ src/bbn_back.sv @@
// Back end: reciprocal divider, scale-and-offset multipliers and result register.
// Depends on bbn_pkg and bbn_res_if.
module bbn_back import bbn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  bbn_entry_t head,
  input  bbn_qstat_t qstat,
  output logic       pop,
  bbn_res_if.source  res
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_EXT  = 5'b00010,
    B_DIV  = 5'b00100,
    B_MUL  = 5'b01000,
    B_OUT  = 5'b10000
  } back_state_t;

  back_state_t st;

  logic [SCALE_W-1:0]       held_scale;
  logic signed [SUM_W-1:0]  csx, csz;
  logic signed [CW-1:0]     by;
  logic [EXT_W-1:0]         ex, ey, ez, den, rem, e_max;
  logic [SCALE_W-1:0]       quo;
  logic [CNT_W-1:0]         cnt;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic signed [PROD_W-1:0] px, py, pz;
  logic signed [PROD_W-1:0] shx, shy, shz;
  logic                     rec, degen;
  logic [EXT_W:0]           rem_sh;
  logic                     ge;
  logic                     load;

  always_comb begin
    e_max = ex;
    if (ey > e_max) e_max = ey;
    if (ez > e_max) e_max = ez;
    rem_sh = {rem, quo[SCALE_W-1]};
    ge     = (rem_sh >= {1'b0, den});
    shx    = px >>> SH_XZ;
    shy    = py >>> SH_Y;
    shz    = pz >>> SH_XZ;
  end

  assign pop  = (st == B_IDLE) && !qstat.empty;
  assign load = (st == B_OUT) && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= B_IDLE;
      held_scale <= ONE_Q31;
      csx        <= '0;
      by         <= '0;
      csz        <= '0;
    end else begin
      unique case (st)
        B_IDLE: begin
          if (!qstat.empty) begin
            rec <= head.rec;
            if (head.rec) begin
              csx <= SUM_W'(head.min_x) + SUM_W'(head.max_x);
              by  <= head.min_y;
              csz <= SUM_W'(head.min_z) + SUM_W'(head.max_z);
              ex  <= EXT_W'(head.max_x - head.min_x);
              ey  <= EXT_W'(head.max_y - head.min_y);
              ez  <= EXT_W'(head.max_z - head.min_z);
              st  <= B_EXT;
            end else begin
              dx    <= (DIFF_W'(head.min_x) <<< 1) - DIFF_W'(csx);
              dy    <= DIFF_W'(head.min_y) - DIFF_W'(by);
              dz    <= (DIFF_W'(head.min_z) <<< 1) - DIFF_W'(csz);
              degen <= 1'b0;
              st    <= B_MUL;
            end
          end
        end
        B_EXT: begin
          dx    <= -DIFF_W'(csx);
          dy    <= -DIFF_W'(by);
          dz    <= -DIFF_W'(csz);
          den   <= e_max;
          degen <= (e_max == '0);
          if (e_max == '0) begin
            held_scale <= ONE_Q31;
            st         <= B_MUL;
          end else begin
            quo <= ONE_Q31;
            rem <= '0;
            cnt <= '0;
            st  <= B_DIV;
          end
        end
        B_DIV: begin
          rem <= ge ? EXT_W'(rem_sh - {1'b0, den}) : rem_sh[EXT_W-1:0];
          quo <= {quo[SCALE_W-2:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(SCALE_W - 1)) begin
            held_scale <= {quo[SCALE_W-2:0], ge};
            st         <= B_MUL;
          end
        end
        B_MUL: begin
          px <= $signed({1'b0, held_scale}) * dx;
          py <= $signed({1'b0, held_scale}) * dy;
          pz <= $signed({1'b0, held_scale}) * dz;
          st <= B_OUT;
        end
        B_OUT: begin
          if (load) st <= B_IDLE;
        end
        default: st <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.kind           <= rec ? KIND_RECORD : KIND_VERTEX;
      res.out_x          <= shx[OUT_W-1:0];
      res.out_y          <= shy[OUT_W-1:0];
      res.out_z          <= shz[OUT_W-1:0];
      res.norm_scale_out <= held_scale;
      res.degenerate     <= degen;
    end
  end

  a_vertex_not_degen: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == KIND_VERTEX) |-> !res.degenerate)
    else $error("degenerate flag on a vertex result");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (st == B_DIV) |-> (den != '0))
    else $error("divide by zero extent");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (st != B_IDLE))
    else $error("job popped but back end stayed idle");

endmodule

@@ src/mesh_bbox_normalize.sv @@
// Top level of the bounding-box normalisation block.
// Depends on bbn_pkg, bbn_if, bbn_front, bbn_queue and bbn_back.
//
// vtx carries vertex requests: cmd 0 measures the vertex into the box, cmd 1
// applies the held normalisation. A measure request with last set closes the
// box and yields one normalisation record; an apply request yields one
// transformed vertex; other measure requests yield nothing.
// res carries results: offsets or normalised coordinates in signed Q17.16,
// scale in unsigned Q1.31 and the degenerate flag on records.
// Measure requests are taken one per cycle while the job queue has room.
// An apply request passes through the job queue and back end states B_IDLE,
// B_MUL and B_OUT, one job at a time; a record also passes B_EXT and, unless
// its extent is zero, the 32-step restoring reciprocal divider.
// Reset clears the box to the type extremes and the held scale to one with
// zero offsets, so apply before any record passes the raw vertex through.
// When res stalls the result is held; the queue absorbs further jobs and vtx
// drops ready once it is full.
module mesh_bbox_normalize import bbn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bbn_vtx_if.sink   vtx,
  bbn_res_if.source res
);

  bbn_push_t  qpush;
  bbn_qstat_t qstat;
  bbn_entry_t head;
  logic       pop;

  bbn_front u_front (
    .clk   (clk),
    .rst   (rst),
    .vtx   (vtx),
    .qstat (qstat),
    .qpush (qpush)
  );

  bbn_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .qpush (qpush),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  bbn_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .res   (res)
  );

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for mesh_bbox_normalize: directed and random vertex streams,
// predicted by a scoreboard class that tracks the box and the held normalisation.
// Depends on bbn_pkg, bbn_if and the block itself.
import bbn_pkg::*;

typedef struct packed {
  logic               kind;
  logic [OUT_W-1:0]   x;
  logic [OUT_W-1:0]   y;
  logic [OUT_W-1:0]   z;
  logic [SCALE_W-1:0] scale;
  logic               degen;
} norm_result_t;

class bbox_norm_board;
  longint lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  longint scale_q31, sum_x, base_y, sum_z;
  norm_result_t pending_results[$];
  int errors, records, degenerates, vertices;

  function new();
    clear_box();
    scale_q31 = longint'(1) << 31;
    sum_x = 0;
    base_y = 0;
    sum_z = 0;
    errors = 0;
    records = 0;
    degenerates = 0;
    vertices = 0;
  endfunction

  function void clear_box();
    longint top;
    top = (longint'(1) << (CW - 1)) - 1;
    lo_x = top; hi_x = -top - 1;
    lo_y = top; hi_y = -top - 1;
    lo_z = top; hi_z = -top - 1;
  endfunction

  // exact product floored once, then wrapped to the output width
  function logic [OUT_W-1:0] floor_q16(longint v, int sh);
    longint q;
    q = v >>> sh;
    return q[OUT_W-1:0];
  endfunction

  function void take_vertex(logic c, logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                            logic signed [CW-1:0] z, logic l);
    longint sx, sy, sz, e;
    norm_result_t r;
    sx = x;
    sy = y;
    sz = z;
    if (c == CMD_APPLY) begin
      r.kind  = KIND_VERTEX;
      r.x     = floor_q16(scale_q31 * (2 * sx - sum_x), SH_XZ);
      r.y     = floor_q16(scale_q31 * (sy - base_y), SH_Y);
      r.z     = floor_q16(scale_q31 * (2 * sz - sum_z), SH_XZ);
      r.scale = scale_q31[SCALE_W-1:0];
      r.degen = 1'b0;
      pending_results.insert(pending_results.size(), r);
      return;
    end
    if (sx < lo_x) lo_x = sx;
    if (sx > hi_x) hi_x = sx;
    if (sy < lo_y) lo_y = sy;
    if (sy > hi_y) hi_y = sy;
    if (sz < lo_z) lo_z = sz;
    if (sz > hi_z) hi_z = sz;
    if (!l) return;
    e = hi_x - lo_x;
    if (hi_y - lo_y > e) e = hi_y - lo_y;
    if (hi_z - lo_z > e) e = hi_z - lo_z;
    r.degen   = (e <= 0);
    scale_q31 = r.degen ? (longint'(1) << 31) : (longint'(1) << 31) / e;
    sum_x     = lo_x + hi_x;
    base_y    = lo_y;
    sum_z     = lo_z + hi_z;
    r.kind    = KIND_RECORD;
    r.x       = floor_q16(-(scale_q31 * sum_x), SH_XZ);
    r.y       = floor_q16(-(scale_q31 * base_y), SH_Y);
    r.z       = floor_q16(-(scale_q31 * sum_z), SH_XZ);
    r.scale   = scale_q31[SCALE_W-1:0];
    pending_results.insert(pending_results.size(), r);
    clear_box();
  endfunction

  function void check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endfunction

  function void match_result(logic kind, logic [OUT_W-1:0] x, logic [OUT_W-1:0] y,
                             logic [OUT_W-1:0] z, logic [SCALE_W-1:0] scale, logic degen);
    norm_result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("result with nothing outstanding: kind %b", kind);
      return;
    end
    want = pending_results.pop_front();
    check_field("kind", OUT_W'(want.kind), OUT_W'(kind));
    check_field("out_x", want.x, x);
    check_field("out_y", want.y, y);
    check_field("out_z", want.z, z);
    check_field("norm_scale_out", OUT_W'(want.scale), OUT_W'(scale));
    check_field("degenerate", OUT_W'(want.degen), OUT_W'(degen));
    if (want.kind == KIND_RECORD) begin
      records++;
      if (want.degen) degenerates++;
    end else begin
      vertices++;
    end
  endfunction

  function void flush_check();
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0d results never arrived", pending_results.size());
    end
  endfunction
endclass

module testbench;
  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int N_RANDOM    = 400;

  logic clk = 1'b0;
  logic rst;

  bbn_vtx_if vtx ();
  bbn_res_if res ();

  mesh_bbox_normalize i_dut (
    .clk (clk),
    .rst (rst),
    .vtx (vtx),
    .res (res)
  );

  bbox_norm_board board = new();

  int  cycles = 0;
  int  requests_sent = 0;
  bit  src_idle = 1'b1;
  bit  snk_idle = 1'b1;
  bit  hold_req = 1'b0;

  always #10 clk = ~clk;

  initial begin
    rst       <= 1'b1;
    vtx.valid <= 1'b0;
    vtx.cmd   <= CMD_MEASURE;
    vtx.vx    <= '0;
    vtx.vy    <= '0;
    vtx.vz    <= '0;
    vtx.last  <= 1'b0;
    res.ready <= 1'b0;
  end

  initial begin : watchdog
    while (cycles <= LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_vertex(input logic c, input logic signed [CW-1:0] x,
                             input logic signed [CW-1:0] y, input logic signed [CW-1:0] z,
                             input logic l);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      vtx.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    vtx.valid <= 1'b1;
    vtx.cmd   <= c;
    vtx.vx    <= x;
    vtx.vy    <= y;
    vtx.vz    <= z;
    vtx.last  <= l;
    do @(posedge clk); while (!vtx.ready);
    board.take_vertex(c, x, y, z, l);
    requests_sent++;
  endtask

  function automatic logic signed [CW-1:0] pick_coord(logic signed [CW-1:0] base, int span);
    if (span < 0) return CW'($urandom);
    return base + CW'($urandom_range(0, span));
  endfunction

  initial begin : result_sink
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        res.ready <= 1'b0;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(posedge clk);
          n++;
        end
        hold_req = 1'b0;
      end else if (snk_idle && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      board.match_result(res.kind, res.out_x, res.out_y, res.out_z,
                         res.norm_scale_out, res.degenerate);
  end

  initial begin : stimulus
    int target, nv, na, span, i;
    bit pressure_done;
    logic signed [CW-1:0] bx, by, bz;
    pressure_done = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pass-through before any record, last ignored on apply
    send_vertex(CMD_APPLY, 32767, -32768, 0, 1'b0);
    send_vertex(CMD_APPLY, -1, 1, -32768, 1'b1);
    // zero extent
    send_vertex(CMD_MEASURE, 5, -7, 100, 1'b1);
    send_vertex(CMD_APPLY, 5, -7, 100, 1'b0);
    send_vertex(CMD_APPLY, -32768, 32767, -32768, 1'b0);
    // full range box
    send_vertex(CMD_MEASURE, -32768, -32768, -32768, 1'b0);
    send_vertex(CMD_MEASURE, 32767, 32767, 32767, 1'b1);
    send_vertex(CMD_APPLY, 32767, 32767, 32767, 1'b0);
    send_vertex(CMD_APPLY, -32768, -32768, -32768, 1'b0);
    send_vertex(CMD_APPLY, 0, 0, 0, 1'b0);
    // extent of one
    send_vertex(CMD_MEASURE, 0, 0, 0, 1'b0);
    send_vertex(CMD_MEASURE, 1, 0, 0, 1'b1);
    send_vertex(CMD_APPLY, 1, 1, 1, 1'b0);
    send_vertex(CMD_APPLY, -32768, 32767, 0, 1'b0);
    // y largest
    send_vertex(CMD_MEASURE, 0, -100, 0, 1'b0);
    send_vertex(CMD_MEASURE, 10, 300, 5, 1'b1);
    send_vertex(CMD_APPLY, 3, -100, 2, 1'b0);
    // x and z tie
    send_vertex(CMD_MEASURE, -50, 0, -50, 1'b0);
    send_vertex(CMD_MEASURE, 50, 20, 50, 1'b1);
    // three-way tie
    send_vertex(CMD_MEASURE, 0, 0, 0, 1'b0);
    send_vertex(CMD_MEASURE, 7, 7, 7, 1'b1);
    send_vertex(CMD_APPLY, -7, 14, 3, 1'b0);
    // apply while a box is still open
    send_vertex(CMD_MEASURE, 100, 100, 100, 1'b0);
    send_vertex(CMD_APPLY, 0, 0, 0, 1'b0);
    send_vertex(CMD_MEASURE, -100, 200, -300, 1'b1);

    target = requests_sent + N_RANDOM;
    while (requests_sent < target) begin
      if (requests_sent > target - 80) begin
        src_idle = 1'b0;
        snk_idle = 1'b0;
      end else begin
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle = ($urandom_range(0, 3) != 0);
      end
      if (!pressure_done && requests_sent > target - N_RANDOM / 2) begin
        src_idle = 1'b0;
        hold_req = 1'b1;
        for (i = 0; i < 24; i++)
          send_vertex(CMD_APPLY, CW'($urandom), CW'($urandom), CW'($urandom),
                      1'($urandom_range(0, 1)));
        pressure_done = 1'b1;
      end
      bx = CW'($urandom);
      by = CW'($urandom);
      bz = CW'($urandom);
      span = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, 1 << $urandom_range(0, 12));
      nv = $urandom_range(1, 8);
      for (i = 0; i < nv; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_vertex(CMD_APPLY, CW'($urandom), CW'($urandom), CW'($urandom),
                      1'($urandom_range(0, 1)));
        // occasionally drop the closing flag so two meshes merge
        send_vertex(CMD_MEASURE, pick_coord(bx, span), pick_coord(by, span),
                    pick_coord(bz, span),
                    (i == nv - 1) && ($urandom_range(0, 9) != 0));
      end
      na = $urandom_range(0, 6);
      for (i = 0; i < na; i++) begin
        if ($urandom_range(0, 4) == 0)
          send_vertex(CMD_APPLY, CW'($urandom), CW'($urandom), CW'($urandom),
                      1'($urandom_range(0, 1)));
        else
          send_vertex(CMD_APPLY, pick_coord(bx, span), pick_coord(by, span),
                      pick_coord(bz, span), 1'($urandom_range(0, 1)));
      end
    end
    vtx.valid <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    board.flush_check();

    $display("Sent %0d vertex requests; checked %0d records (%0d degenerate)",
             requests_sent, board.records, board.degenerates);
    $display("and %0d transformed vertices, with %0d mismatches", board.vertices, board.errors);
    if (board.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
